/* sv/epsc_pkg.sv */
// Shared types and constants for the encoder period speed controller.
`timescale 1ns / 1ps
package epsc_pkg;

   typedef enum logic [1:0] {
      CMD_US_TICK = 2'd0,
      CMD_ADC     = 2'd1,
      CMD_CONTROL = 2'd2,
      CMD_SENSOR  = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_SETTLE_COUNT = 1'd0,
      CSR_CLAMP_LEVEL  = 1'd1
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [7:0]  SETTLE_COUNT_RESET = 8'd20;
   localparam logic [7:0]  CLAMP_LEVEL_RESET  = 8'd250;
   localparam logic [7:0]  BYTE_MAX           = 8'hFF;
   localparam logic [15:0] TIMER_MAX          = 16'hFFFF;
   localparam logic [15:0] TIMER_SLOW         = 16'hFF00;

   typedef struct packed {
      logic [7:0] settle_count;
      logic [7:0] clamp_level;
   } cfg_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] adc_value;
      logic       sensor_level;
   } item_type;

   typedef struct packed {
      logic [7:0] pwm_duty;
      logic [7:0] setpoint_out;
      logic [7:0] error_out;
      logic [7:0] period_out;
      logic       captured;
   } result_type;

endpackage

/* sv/epsc_req_if.sv */
// Input channel interface: valid/ready handshake with one command item.
`timescale 1ns / 1ps
interface epsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] adc_value;
   logic       sensor_level;

   modport source (output valid, output cmd, output adc_value, output sensor_level,
                   input ready);
   modport sink   (input valid, input cmd, input adc_value, input sensor_level,
                   output ready);
endinterface

/* sv/epsc_rsp_if.sv */
// Result channel interface: valid/ready handshake with one result item.
`timescale 1ns / 1ps
interface epsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pwm_duty;
   logic [7:0] setpoint_out;
   logic [7:0] error_out;
   logic [7:0] period_out;
   logic       captured;

   modport source (output valid, output pwm_duty, output setpoint_out, output error_out,
                   output period_out, output captured, input ready);
   modport sink   (input valid, input pwm_duty, input setpoint_out, input error_out,
                   input period_out, input captured, output ready);
endinterface

/* sv/epsc_core.sv */
// Controller state and single-pass update for one command item.
`timescale 1ns / 1ps
module epsc_core
   import epsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       item_valid,
   input  item_type   item,
   output result_type result
);

   logic [15:0] timer_ff,    timer_in;
   logic        running_ff,  running_in;
   logic [7:0]  debounce_ff, debounce_in;
   logic [7:0]  setpoint_ff, setpoint_in;
   logic [7:0]  period_ff,   period_in;
   logic [7:0]  error_ff,    error_in;
   logic [7:0]  duty_ff,     duty_in;
   logic        captured;
   logic [7:0]  count_inc;
   logic [7:0]  count_clr;
   logic [7:0]  err;

   always_comb begin
      timer_in    = timer_ff;
      running_in  = running_ff;
      debounce_in = debounce_ff;
      setpoint_in = setpoint_ff;
      period_in   = period_ff;
      error_in    = error_ff;
      duty_in     = duty_ff;
      captured    = 1'b0;
      // saturating count, cleared while the sensor is high
      count_inc   = (debounce_ff != BYTE_MAX) ? debounce_ff + 8'd1 : debounce_ff;
      count_clr   = item.sensor_level ? 8'd0 : count_inc;
      // setpoint - (255 - period) mod 256
      err         = setpoint_ff + period_ff + 8'd1;
      if (item_valid) begin
         unique case (item.cmd)
            CMD_US_TICK: begin
               if (running_ff) begin
                  if (timer_ff == TIMER_MAX) begin
                     running_in = 1'b0;
                     timer_in   = TIMER_SLOW;
                  end else begin
                     timer_in = timer_ff + 16'd1;
                  end
               end
            end
            CMD_ADC: begin
               setpoint_in = (item.adc_value > cfg.clamp_level) ? BYTE_MAX : item.adc_value;
            end
            CMD_CONTROL: begin
               error_in = err;
               duty_in  = {1'b0, err[7:1]} + {2'b0, err[7:2]} + {3'b0, err[7:3]};
            end
            CMD_SENSOR: begin
               debounce_in = count_clr;
               if (count_clr == cfg.settle_count) begin
                  period_in   = timer_ff[15:8];
                  running_in  = 1'b1;
                  timer_in    = 16'd0;
                  debounce_in = count_clr + 8'd1;
                  captured    = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff    <= 16'd0;
         running_ff  <= 1'b1;
         debounce_ff <= 8'd0;
         setpoint_ff <= 8'd0;
         period_ff   <= 8'd0;
         error_ff    <= 8'd0;
         duty_ff     <= 8'd0;
      end else begin
         timer_ff    <= timer_in;
         running_ff  <= running_in;
         debounce_ff <= debounce_in;
         setpoint_ff <= setpoint_in;
         period_ff   <= period_in;
         error_ff    <= error_in;
         duty_ff     <= duty_in;
      end
   end

   assign result.pwm_duty     = duty_in;
   assign result.setpoint_out = setpoint_in;
   assign result.error_out    = error_in;
   assign result.period_out   = period_in;
   assign result.captured     = captured;

endmodule

/* sv/encoder_period_p_speed_control_top.sv */
// Top level of the encoder period proportional speed controller.
`timescale 1ns / 1ps
// Usage:
//   req_chan carries one command per transfer: microsecond tick, ADC sample,
//   control tick or sensor sample. rsp_chan returns exactly one result per
//   command: duty, setpoint, error, measured period and a capture flag.
//   csr_we/csr_index/csr_wdata write settle_count (index 0) and clamp_level
//   (index 1); write them only while no command is in flight.
// Result path: the controller state updates in the cycle a command transfers,
//   and its result is registered into the head entry (skid entry if head is held).
// Throughput: one command per cycle while req_chan.ready is high; the state
//   update in epsc_core never stalls.
// Stall: results queue in a two-entry buffer (output register plus skid
//   register). req_chan.ready is registered and drops only when both entries
//   hold results, so an item is still taken while one result waits.
// Reset: synchronous, active high. Timer restarts running from zero, all
//   controller state clears, registers return to 20 and 250, buffer empties.
module encoder_period_p_speed_control_top
   import epsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   epsc_req_if.sink              req_chan,
   epsc_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   item_type   item;
   logic       push;
   logic       pop;
   result_type result;

   logic       head_valid_ff, head_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;

   // configuration write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SETTLE_COUNT: cfg_in.settle_count = csr_wdata;
            CSR_CLAMP_LEVEL:  cfg_in.clamp_level  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_count <= SETTLE_COUNT_RESET;
         cfg_ff.clamp_level  <= CLAMP_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // accept while the skid entry is free
   assign req_chan.ready = !skid_valid_ff;
   assign push           = req_chan.valid && !skid_valid_ff;
   assign pop            = head_valid_ff && rsp_chan.ready;

   assign item.cmd          = cmd_type'(req_chan.cmd);
   assign item.adc_value    = req_chan.adc_value;
   assign item.sensor_level = req_chan.sensor_level;

   epsc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (push),
      .item       (item),
      .result     (result)
   );

   // two-entry result buffer: head drives the channel, skid absorbs a stall
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            // advance skid into head; no push possible this cycle
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = push;
            head_in       = result;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload holds need no reset
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = head_valid_ff;
   assign rsp_chan.pwm_duty     = head_ff.pwm_duty;
   assign rsp_chan.setpoint_out = head_ff.setpoint_out;
   assign rsp_chan.error_out    = head_ff.error_out;
   assign rsp_chan.period_out   = head_ff.period_out;
   assign rsp_chan.captured     = head_ff.captured;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the encoder period proportional speed controller.
`timescale 1ns / 1ps
module tb;
   import epsc_pkg::*;

   // One row of the directed stimulus: an item repeated reps times; where
   // fixed_check is set, the result of the last repetition must equal want.
   typedef struct {
      cmd_type     cmd;
      logic [7:0]  adc_value;
      logic        sensor_level;
      int unsigned reps;
      bit          fixed_check;
      result_type  want;
   } directed_row_type;

   localparam int unsigned NUM_ROWS     = 23;
   localparam int unsigned NUM_PHASES   = 6;
   localparam int unsigned PHASE_ITEMS  = 40;
   localparam int unsigned DRAIN_LIMIT  = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   epsc_req_if req_chan ();
   epsc_rsp_if rsp_chan ();

   encoder_period_p_speed_control_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the controller state, updated on every accepted transfer.
   logic [15:0] timer_q;
   bit          timer_on;
   logic [7:0]  debounce_q;
   logic [7:0]  setpoint_q;
   logic [7:0]  period_q;
   logic [7:0]  error_q;
   logic [7:0]  duty_q;
   logic [7:0]  settle_q;
   logic [7:0]  clamp_q;

   result_type       pending_results [$];
   int unsigned      mismatch_count = 0;
   int unsigned      items_sent = 0;
   bit               pace_hold = 1'b0;
   directed_row_type directed_rows [NUM_ROWS];

   // Sender and receiver pacing: stretches of back-to-back traffic
   // alternate with stretches of random gaps.
   int unsigned req_stretch = 0;
   bit          req_burst = 1'b0;
   int unsigned rsp_stretch = 0;
   bit          rsp_burst = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Advance the mirrored controller by one item and return its result.
   function automatic result_type speed_loop_step(input item_type it);
      result_type r;
      logic [7:0] e;
      r.captured = 1'b0;
      case (it.cmd)
         CMD_US_TICK: begin
            // Stopped timer holds; the wrapping tick stops it at the slow mark.
            if (timer_on) begin
               if (timer_q == TIMER_MAX) begin
                  timer_on = 1'b0;
                  timer_q  = TIMER_SLOW;
               end else begin
                  timer_q = timer_q + 16'd1;
               end
            end
         end
         CMD_ADC: begin
            setpoint_q = (it.adc_value > clamp_q) ? BYTE_MAX : it.adc_value;
         end
         CMD_CONTROL: begin
            e       = setpoint_q - (BYTE_MAX - period_q);
            error_q = e;
            duty_q  = (e >> 1) + (e >> 2) + (e >> 3);
         end
         CMD_SENSOR: begin
            // Saturating count, cleared while high, then compared.
            if (debounce_q != BYTE_MAX)
               debounce_q = debounce_q + 8'd1;
            if (it.sensor_level)
               debounce_q = 8'd0;
            if (debounce_q == settle_q) begin
               period_q   = timer_q[15:8];
               timer_on   = 1'b1;
               timer_q    = 16'd0;
               debounce_q = debounce_q + 8'd1;
               r.captured = 1'b1;
            end
         end
      endcase
      r.pwm_duty     = duty_q;
      r.setpoint_out = setpoint_q;
      r.error_out    = error_q;
      r.period_out   = period_q;
      return r;
   endfunction

   function automatic item_type make_item(input cmd_type c, input logic level);
      item_type it;
      it.cmd          = c;
      it.adc_value    = 8'($urandom_range(0, 255));
      it.sensor_level = level;
      return it;
   endfunction

   // Drive one item from the falling edge and hold it until the transfer.
   task automatic send_item(input item_type it);
      int unsigned gap;
      if (req_stretch == 0) begin
         req_stretch = $urandom_range(20, 80);
         req_burst   = ($urandom_range(0, 3) == 0);
      end
      req_stretch--;
      gap = (req_burst || pace_hold) ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.cmd          <= it.cmd;
      req_chan.adc_value    <= it.adc_value;
      req_chan.sensor_level <= it.sensor_level;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_results.push_back(speed_loop_step(it));
      items_sent++;
   endtask

   // Drop valid, then wait for every outstanding result plus a little slack.
   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         report_mismatch("results never returned", pending_results.size(), 0);
         pending_results.delete();
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_SETTLE_COUNT: settle_q = value;
         CSR_CLAMP_LEVEL:  clamp_q  = value;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Well-formed encoder edge: sensor high, then enough low samples to
   // settle, with ticks, setpoint updates and control ticks mixed in.
   task automatic drive_capture_sequence();
      int unsigned lows;
      int unsigned burst;
      bit          bounced;
      bounced = 1'b0;
      repeat ($urandom_range(1, 3)) send_item(make_item(CMD_SENSOR, 1'b1));
      lows = settle_q;
      for (int unsigned k = 0; k < lows; k++) begin
         case ($urandom_range(0, 19))
            0: begin
               burst = $urandom_range(1, 6);
               repeat (burst) send_item(make_item(CMD_US_TICK, 1'($urandom)));
            end
            1: send_item(make_item(CMD_ADC, 1'($urandom)));
            2: send_item(make_item(CMD_CONTROL, 1'($urandom)));
            3: begin
               // Bounce once near the start: restart the debounce count.
               if (!bounced && k < 16) begin
                  send_item(make_item(CMD_SENSOR, 1'b1));
                  bounced = 1'b1;
                  k = 0;
               end
            end
            default: ;
         endcase
         send_item(make_item(CMD_SENSOR, 1'b0));
      end
      send_item(make_item(CMD_CONTROL, 1'($urandom)));
   endtask

   task automatic run_random_phase(input int unsigned budget);
      int unsigned target;
      item_type    it;
      target = items_sent + budget;
      while (items_sent < target) begin
         case ($urandom_range(0, 29))
            0: begin
               // Long low run: a stretch of low sensor samples in a row.
               repeat ($urandom_range(20, 60))
                  send_item(make_item(CMD_SENSOR, 1'b0));
            end
            1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14: drive_capture_sequence();
            15, 16, 17, 18, 19: begin
               send_item(make_item(CMD_ADC, 1'($urandom)));
               send_item(make_item(CMD_CONTROL, 1'($urandom)));
            end
            default: begin
               it.cmd          = cmd_type'($urandom_range(0, 3));
               it.adc_value    = 8'($urandom_range(0, 255));
               it.sensor_level = 1'($urandom);
               send_item(it);
            end
         endcase
      end
   endtask

   // Receiver: stall at random, then compare each result transfer with the
   // oldest expectation, field by field.
   initial begin : result_monitor
      int unsigned stall;
      result_type  want;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (rsp_stretch == 0) begin
            rsp_stretch = $urandom_range(20, 80);
            rsp_burst   = ($urandom_range(0, 3) == 0);
         end
         rsp_stretch--;
         stall = (rsp_burst || pace_hold) ? 0 : $urandom_range(0, 10);
         @(negedge clock);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_chan.pwm_duty, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.pwm_duty !== want.pwm_duty)
               report_mismatch("pwm_duty", rsp_chan.pwm_duty, want.pwm_duty);
            if (rsp_chan.setpoint_out !== want.setpoint_out)
               report_mismatch("setpoint_out", rsp_chan.setpoint_out, want.setpoint_out);
            if (rsp_chan.error_out !== want.error_out)
               report_mismatch("error_out", rsp_chan.error_out, want.error_out);
            if (rsp_chan.period_out !== want.period_out)
               report_mismatch("period_out", rsp_chan.period_out, want.period_out);
            if (rsp_chan.captured !== want.captured)
               report_mismatch("captured", rsp_chan.captured, want.captured);
         end
      end
   end

   // Main sequence: reset, directed table, then random phases under
   // several register settings.
   initial begin : stimulus
      item_type    it;
      logic [7:0]  phase_settle [NUM_PHASES];
      logic [7:0]  phase_clamp  [NUM_PHASES];

      // Hold every input at a known value from time zero.
      req_chan.valid        = 1'b0;
      req_chan.cmd          = CMD_US_TICK;
      req_chan.adc_value    = 8'd0;
      req_chan.sensor_level = 1'b0;
      csr_we                = 1'b0;
      csr_index             = CSR_SETTLE_COUNT;
      csr_wdata             = '0;

      // Reset state of the mirror.
      timer_q    = 16'd0;
      timer_on   = 1'b1;
      debounce_q = 8'd0;
      setpoint_q = 8'd0;
      period_q   = 8'd0;
      error_q    = 8'd0;
      duty_q     = 8'd0;
      settle_q   = SETTLE_COUNT_RESET;
      clamp_q    = CLAMP_LEVEL_RESET;

      // Directed rows, walked from reset with the default registers
      // (settle 20, clamp 250). Unused fields carry arbitrary values.
      directed_rows = '{
         // error after reset: 0 - (255 - 0) wraps to 1
         '{CMD_CONTROL, 8'hFF, 1'b1, 1,     1'b1, '{8'd0,   8'd0,   8'd1,   8'd0,   1'b0}},
         '{CMD_ADC,     8'd0,  1'b1, 1,     1'b1, '{8'd0,   8'd0,   8'd1,   8'd0,   1'b0}},
         // clamp boundary: equal passes, one above forces full scale
         '{CMD_ADC,     8'd250, 1'b0, 1,    1'b1, '{8'd0,   8'd250, 8'd1,   8'd0,   1'b0}},
         '{CMD_ADC,     8'd251, 1'b0, 1,    1'b1, '{8'd0,   8'd255, 8'd1,   8'd0,   1'b0}},
         '{CMD_ADC,     8'd255, 1'b1, 1,    1'b1, '{8'd0,   8'd255, 8'd1,   8'd0,   1'b0}},
         '{CMD_CONTROL, 8'd0,  1'b0, 1,     1'b1, '{8'd0,   8'd255, 8'd0,   8'd0,   1'b0}},
         // first edge: clear, settle, capture with the timer at zero
         '{CMD_SENSOR,  8'd0,  1'b1, 1,     1'b1, '{8'd0,   8'd255, 8'd0,   8'd0,   1'b0}},
         '{CMD_SENSOR,  8'hA5, 1'b0, 19,    1'b0, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}},
         '{CMD_SENSOR,  8'h5A, 1'b0, 1,     1'b1, '{8'd0,   8'd255, 8'd0,   8'd0,   1'b1}},
         // run the timer past one step of its high byte (260 ticks)
         '{CMD_US_TICK, 8'hFF, 1'b1, 256,   1'b1, '{8'd0,   8'd255, 8'd0,   8'd0,   1'b0}},
         '{CMD_US_TICK, 8'h00, 1'b0, 1,     1'b1, '{8'd0,   8'd255, 8'd0,   8'd0,   1'b0}},
         '{CMD_US_TICK, 8'h3C, 1'b1, 3,     1'b0, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}},
         // next edge captures the high byte of the elapsed ticks
         '{CMD_SENSOR,  8'hC3, 1'b1, 1,     1'b0, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}},
         '{CMD_SENSOR,  8'h0F, 1'b0, 19,    1'b0, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}},
         '{CMD_SENSOR,  8'hF0, 1'b0, 1,     1'b1, '{8'd0,   8'd255, 8'd0,   8'd1,   1'b1}},
         // error 250 - 254 wraps to 252, duty 126 + 63 + 31
         '{CMD_ADC,     8'd250, 1'b1, 1,    1'b1, '{8'd0,   8'd250, 8'd0,   8'd1,   1'b0}},
         '{CMD_CONTROL, 8'h81, 1'b1, 1,     1'b1, '{8'd220, 8'd250, 8'd252, 8'd1,   1'b0}},
         '{CMD_ADC,     8'd0,  1'b0, 1,     1'b1, '{8'd220, 8'd0,   8'd252, 8'd1,   1'b0}},
         '{CMD_CONTROL, 8'h7E, 1'b0, 1,     1'b1, '{8'd1,   8'd0,   8'd2,   8'd1,   1'b0}},
         '{CMD_ADC,     8'd128, 1'b1, 1,    1'b0, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}},
         '{CMD_CONTROL, 8'h11, 1'b1, 1,     1'b0, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}},
         '{CMD_SENSOR,  8'h22, 1'b0, 1,     1'b0, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}},
         '{CMD_US_TICK, 8'h44, 1'b0, 5,     1'b0, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}}
      };

      // Register settings per random phase: defaults, then extremes, then random.
      phase_settle = '{8'd20, 8'd0, 8'd255, 8'd1, 8'd254, 8'd0};
      phase_clamp  = '{8'd250, 8'd0, 8'd255, 8'd128, 8'd1, 8'd0};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      foreach (directed_rows[i]) begin
         // Keep long tick runs back to back on both sides.
         pace_hold = (directed_rows[i].reps > 100);
         it.cmd          = directed_rows[i].cmd;
         it.adc_value    = directed_rows[i].adc_value;
         it.sensor_level = directed_rows[i].sensor_level;
         repeat (directed_rows[i].reps) send_item(it);
         if (directed_rows[i].fixed_check)
            pending_results[$] = directed_rows[i].want;
      end
      pace_hold = 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p >= 5) begin
            phase_settle[p] = 8'($urandom_range(1, 60));
            phase_clamp[p]  = 8'($urandom_range(0, 255));
         end
         // Reprogram only once the pipeline is empty.
         drain_results();
         write_csr(CSR_SETTLE_COUNT, phase_settle[p]);
         write_csr(CSR_CLAMP_LEVEL, phase_clamp[p]);
         run_random_phase(PHASE_ITEMS + phase_settle[p]);
      end

      drain_results();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
